// File: design/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro samples on the rising edge of clk; all but CHECK_AFTER_RESET are disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// A consequence that must follow a reset cycle, checked during reset too.
`define CHECK_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// File: design/spq_pkg.sv
package spq_pkg;

  // Operation carried by one request.
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  // Status reported with every result.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Widths of the stream fields.
  localparam int FIELD_BITS   = 16;
  localparam int OCC_OUT_BITS = 5;

  // Command queue between the front and the back.
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = 1;
  localparam int QFILL_BITS = 2;

  // Decoded request handed from the front to the back.
  typedef struct packed {
    op_t                   op;
    logic [FIELD_BITS-1:0] id;
    logic [FIELD_BITS-1:0] count;
  } cmd_t;

  // Result handed from the back to the output port.
  typedef struct packed {
    logic [FIELD_BITS-1:0]   id;
    logic [FIELD_BITS-1:0]   count;
    status_t                 status;
    logic [OCC_OUT_BITS-1:0] occ;
  } result_t;

endpackage

// File: design/spq_front.sv
module spq_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [31:0]     s_tdata,   // item_id [15:0], item_count [31:16]
  input  logic [0:0]      s_tuser,   // action [0]
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output spq_pkg::cmd_t   cmd
);

  spq_pkg::cmd_t                     q [spq_pkg::QDEPTH];
  spq_pkg::cmd_t                     cmd_in;
  logic [spq_pkg::QPTR_BITS-1:0]     wr_ptr;
  logic [spq_pkg::QPTR_BITS-1:0]     rd_ptr;
  logic [spq_pkg::QFILL_BITS-1:0]    fill;
  logic                              push;
  logic                              pop;

  // Decode the incoming request into a command.
  always_comb begin
    cmd_in.op    = spq_pkg::op_t'(s_tuser[0]);
    cmd_in.id    = s_tdata[15:0];
    cmd_in.count = s_tdata[31:16];
  end

  // Queue handshakes on both sides.
  assign s_tready  = (fill != spq_pkg::QFILL_BITS'(spq_pkg::QDEPTH));
  assign cmd_valid = (fill != '0);
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

endmodule

// File: design/spq_back.sv
module spq_back #(
  parameter int CAPACITY   = 16,
  parameter int ID_BITS    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  spq_pkg::cmd_t     cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output spq_pkg::result_t  res
);

  localparam int OCC_BITS = $clog2(CAPACITY + 1);

  logic [ID_BITS-1:0]    slot_id    [CAPACITY];
  logic [COUNT_BITS-1:0] slot_count [CAPACITY];
  logic [ID_BITS-1:0]    up_id      [CAPACITY];
  logic [COUNT_BITS-1:0] up_count   [CAPACITY];
  logic [ID_BITS-1:0]    dn_id      [CAPACITY];
  logic [COUNT_BITS-1:0] dn_count   [CAPACITY];
  logic [CAPACITY-1:0]   gt;
  logic [CAPACITY-1:0]   prev_gt;
  logic [OCC_BITS-1:0]   occ;
  logic [OCC_BITS-1:0]   occ_next;
  logic [ID_BITS-1:0]    new_id;
  logic [COUNT_BITS-1:0] new_count;
  logic                  take;
  logic                  full;
  logic                  empty;
  logic                  do_enq;
  logic                  do_deq;
  spq_pkg::result_t      res_next;

  // One command per cycle whenever the result register is free or draining.
  assign cmd_ready = !res_valid || res_ready;
  assign take      = cmd_valid && cmd_ready;
  assign full      = (occ == OCC_BITS'(CAPACITY));
  assign empty     = (occ == '0);
  assign do_enq    = take && (cmd.op == spq_pkg::OP_ENQ) && !full;
  assign do_deq    = take && (cmd.op == spq_pkg::OP_DEQ) && !empty;
  assign new_id    = ID_BITS'(32'(cmd.id));
  assign new_count = COUNT_BITS'(32'(cmd.count));

  // Per-slot compare and neighbor wiring.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    localparam logic [OCC_BITS-1:0] SLOT_IDX = OCC_BITS'(i);

    assign gt[i] = (occ > SLOT_IDX) && (slot_count[i] > new_count);

    if (i == 0) begin : g_head
      assign prev_gt[i]  = 1'b1;
      assign up_id[i]    = slot_id[i];
      assign up_count[i] = slot_count[i];
    end else begin : g_body
      assign prev_gt[i]  = gt[i-1];
      assign up_id[i]    = slot_id[i-1];
      assign up_count[i] = slot_count[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign dn_id[i]    = slot_id[i];
      assign dn_count[i] = slot_count[i];
    end else begin : g_inner
      assign dn_id[i]    = slot_id[i+1];
      assign dn_count[i] = slot_count[i+1];
    end
  end

  // Sorted slots: insert after the strictly greater prefix, or shift toward the head.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_enq && !gt[i]) begin
        slot_id[i]    <= prev_gt[i] ? new_id : up_id[i];
        slot_count[i] <= prev_gt[i] ? new_count : up_count[i];
      end else if (do_deq) begin
        slot_id[i]    <= dn_id[i];
        slot_count[i] <= dn_count[i];
      end
    end
  end

  // Occupancy after this command.
  always_comb begin
    occ_next = occ;
    if (do_enq) begin
      occ_next = occ + OCC_BITS'(1);
    end else if (do_deq) begin
      occ_next = occ - OCC_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // Result of the current command.
  always_comb begin
    res_next.id     = '0;
    res_next.count  = '0;
    res_next.status = spq_pkg::ST_DONE;
    res_next.occ    = spq_pkg::OCC_OUT_BITS'(32'(occ_next));
    if (cmd.op == spq_pkg::OP_ENQ) begin
      if (full) begin
        res_next.status = spq_pkg::ST_FULL;
      end
    end else if (empty) begin
      res_next.status = spq_pkg::ST_EMPTY;
    end else begin
      res_next.id    = spq_pkg::FIELD_BITS'(32'(slot_id[0]));
      res_next.count = spq_pkg::FIELD_BITS'(32'(slot_count[0]));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

// File: design/sorted_priority_queue_unit.sv
// Channel   Dir  tdata                                          tuser
// s_*       in   item_id [15:0], item_count [31:16]             action [0]
// m_*       out  out_id [15:0], out_count [31:16], occ [36:32]  status [1:0]
//
// A request is written into the command queue at the edge that accepts it and its
// result is loaded into the output register when the back takes the command.
// One request per cycle is sustained while the output is not stalled; the per-slot
// compare-and-shift array then executes one command each cycle.
// Reset empties the queue, the command queue and the output register at once.
// A stalled output holds its result while the front keeps taking up to two requests.
module sorted_priority_queue_unit #(
  parameter int CAPACITY   = 16,
  parameter int ID_BITS    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // item_id [15:0], item_count [31:16]
  input  logic [0:0]  s_tuser,   // action [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_id [15:0], out_count [31:16], occupancy_now [36:32]
  output logic [1:0]  m_tuser    // status [1:0]
);

  logic              cmd_valid;
  logic              cmd_ready;
  spq_pkg::cmd_t     cmd;
  spq_pkg::result_t  res;

  // Front: accept, decode and queue requests.
  spq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Back: sorted slot array and output register.
  spq_back #(
    .CAPACITY   (CAPACITY),
    .ID_BITS    (ID_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // Pack the result onto the output stream.
  assign m_tdata = {3'b000, res.occ, res.count, res.id};
  assign m_tuser = res.status;

endmodule

// File: design/spq_checker.sv
`include "assert_macros.svh"

module spq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A stalled result keeps its contents.
  `CHECK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // Failed requests return no entry.
  `CHECK_ALWAYS(a_fail_no_entry, !(m_tvalid && (m_tuser == spq_pkg::ST_EMPTY || m_tuser == spq_pkg::ST_FULL)) || (m_tdata[31:0] == 32'd0), "failed request returned an entry")

  // A dequeue on an empty queue leaves it empty.
  `CHECK_ALWAYS(a_empty_occ, !(m_tvalid && m_tuser == spq_pkg::ST_EMPTY) || (m_tdata[36:32] == 5'd0), "empty result with nonzero occupancy")

  // The padding bits above the occupancy stay clear.
  `CHECK_ALWAYS(a_pad_zero, !m_tvalid || (m_tdata[39:37] == 3'd0), "result padding bits set")

  // Reset leaves no result pending and the input open.
  `CHECK_AFTER_RESET(a_reset_idle, !m_tvalid && s_tready, "output or input busy after reset")

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
